@@ sv/tnwd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger number decoder package
// Shared constants, register indexes and the record types used by the
// front end, the record queue and the back end.
// ----------------------------------------------------------------------------
package tnwd_pkg;

   localparam int unsigned MaxRecordLen = 65536;
   localparam int unsigned MaxCodeBits  = 32;
   localparam int unsigned IdxWidth     = $clog2(MaxRecordLen) + 1;
   localparam int unsigned CntWidth     = 6;
   localparam int unsigned CodeWidth    = 32;
   localparam int unsigned WrapWidth    = 24;
   localparam int unsigned EventWidth   = 48;
   localparam int unsigned QueueDepth   = 4;
   localparam int unsigned QueueAw      = $clog2(QueueDepth);

   localparam logic [15:0]         FirstBitReset  = 16'd4600;
   localparam logic [15:0]         SpacingReset   = 16'd250;
   localparam logic [CntWidth-1:0] CountReset     = 6'd16;
   localparam logic [15:0]         ThresholdReset = 16'hFE70;

   typedef enum logic [1:0] {
      CSR_FIRST_BIT = 2'd0,
      CSR_SPACING   = 2'd1,
      CSR_COUNT     = 2'd2,
      CSR_THRESHOLD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0]         first_bit_index;
      logic [15:0]         bit_spacing;
      logic [CntWidth-1:0] bit_count;
      logic signed [15:0]  low_threshold;
   } cfg_type;

   // One finished record as handed from the front end to the back end.
   typedef struct packed {
      logic [CodeWidth-1:0] code;
      logic [CntWidth-1:0]  taken;
      logic [CntWidth-1:0]  count;
   } record_type;

   typedef struct packed {
      logic [EventWidth-1:0] event_number;
      logic [WrapWidth-1:0]  wrap_count;
      logic                  short_record;
   } result_type;

endpackage

@@ sv/tnwd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger number decoder front end
// Tracks the sample position within a record, samples the bit positions
// against the threshold and hands each finished record to the queue.
// ----------------------------------------------------------------------------
module tnwd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  tnwd_pkg::cfg_type    cfg,
   input  logic                 sample_valid,
   input  logic signed [15:0]   sample_value,
   input  logic                 record_end,
   output logic                 rec_valid,
   output tnwd_pkg::record_type rec
);
   import tnwd_pkg::*;

   logic [IdxWidth-1:0]  sample_index_ff, sample_index_in;
   logic [IdxWidth-1:0]  next_bit_ff, next_bit_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   logic [CntWidth-1:0]  taken_ff, taken_in;

   logic [CntWidth-1:0]  eff_count;
   logic [IdxWidth-1:0]  cur_bit;
   logic [IdxWidth:0]    bit_sum;
   logic [IdxWidth-1:0]  bit_step;
   logic                 take;
   logic                 bit_one;
   logic [CodeWidth-1:0] code_new;
   logic [CntWidth-1:0]  taken_new;

   always_comb begin
      eff_count = (cfg.bit_count > CntWidth'(MaxCodeBits)) ? CntWidth'(MaxCodeBits)
                                                           : cfg.bit_count;
      cur_bit   = (sample_index_ff == '0) ? IdxWidth'(cfg.first_bit_index) : next_bit_ff;
      take      = (taken_ff < eff_count) && (sample_index_ff < IdxWidth'(MaxRecordLen))
                  && (sample_index_ff == cur_bit);
      bit_one   = sample_value < cfg.low_threshold;
      bit_sum   = {1'b0, cur_bit} + (IdxWidth + 1)'(cfg.bit_spacing);
      bit_step  = (bit_sum > (IdxWidth + 1)'(MaxRecordLen)) ? IdxWidth'(MaxRecordLen)
                                                             : bit_sum[IdxWidth-1:0];
      code_new  = take ? {code_ff[CodeWidth-2:0], bit_one} : code_ff;
      taken_new = take ? taken_ff + 1'b1 : taken_ff;

      sample_index_in = sample_index_ff;
      next_bit_in     = next_bit_ff;
      code_in         = code_ff;
      taken_in        = taken_ff;
      if (sample_valid) begin
         if (record_end) begin
            sample_index_in = '0;
            next_bit_in     = IdxWidth'(cfg.first_bit_index);
            code_in         = '0;
            taken_in        = '0;
         end else begin
            if (sample_index_ff < IdxWidth'(MaxRecordLen)) begin
               sample_index_in = sample_index_ff + 1'b1;
            end
            next_bit_in = take ? bit_step : cur_bit;
            code_in     = code_new;
            taken_in    = taken_new;
         end
      end

      rec_valid = sample_valid && record_end;
      rec.code  = code_new;
      rec.taken = taken_new;
      rec.count = eff_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         next_bit_ff     <= IdxWidth'(FirstBitReset);
         code_ff         <= '0;
         taken_ff        <= '0;
      end else begin
         sample_index_ff <= sample_index_in;
         next_bit_ff     <= next_bit_in;
         code_ff         <= code_in;
         taken_ff        <= taken_in;
      end
   end

`ifndef SYNTHESIS
   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      taken_ff <= CntWidth'(MaxCodeBits))
      else $error("front: bits taken exceeds the code width");
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      sample_index_ff <= IdxWidth'(MaxRecordLen) && next_bit_ff <= IdxWidth'(MaxRecordLen))
      else $error("front: sample position beyond the record limit");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rec_valid |=> (sample_index_ff == '0 && taken_ff == '0 && code_ff == '0))
      else $error("front: record state not cleared after record end");
`endif

endmodule

@@ sv/tnwd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger number decoder record queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tnwd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  tnwd_pkg::record_type wr_data,
   output logic                 full,
   input  logic                 rd_en,
   output tnwd_pkg::record_type rd_data,
   output logic                 empty
);
   import tnwd_pkg::*;

   record_type           mem_ff [QueueDepth];
   logic [QueueAw-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueueAw-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]     count_ff, count_in;
   logic                 do_wr, do_rd;

   always_comb begin
      full      = count_ff == (QueueAw + 1)'(QueueDepth);
      empty     = count_ff == '0;
      do_wr     = wr_en && !full;
      do_rd     = rd_en && !empty;
      rd_data   = mem_ff[rd_ptr_ff];
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QueueAw + 1)'(do_wr) - (QueueAw + 1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QueueAw + 1)'(QueueDepth))
      else $error("queue: occupancy beyond depth");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QueueAw-1:0])
      else $error("queue: pointers disagree with occupancy");
   a_no_lost: assert property (@(posedge clock) disable iff (reset)
      (wr_en && full) |-> 1'b0)
      else $error("queue: write into a full queue");
`endif

endmodule

@@ sv/tnwd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger number decoder back end
// Pads short codes, extends each code with the wrap count and buffers the
// results for the output side.
// ----------------------------------------------------------------------------
module tnwd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rec_empty,
   input  tnwd_pkg::record_type  rec,
   output logic                  rec_pop,
   input  logic                  pop,
   output logic                  empty,
   output tnwd_pkg::result_type  rsp
);
   import tnwd_pkg::*;

   // Stage one: padded code.
   logic                   a_vld_ff, a_vld_in;
   logic [CodeWidth-1:0]   a_code_ff, a_code_in;
   logic                   a_short_ff, a_short_in;

   // Running state.
   logic [WrapWidth-1:0]   wrap_ff, wrap_in;
   logic [EventWidth-1:0]  prev_ff, prev_in;

   // Two-entry output buffer.
   result_type             ob_ff [2];
   logic                   ob_wr_ff, ob_wr_in;
   logic                   ob_rd_ff, ob_rd_in;
   logic [1:0]             ob_cnt_ff, ob_cnt_in;

   logic                   b_fire, a_ready, ob_pop;
   logic [CntWidth-1:0]    shamt;
   logic [2*CodeWidth-1:0] shifted;
   logic [WrapWidth-1:0]   wrap_inc;
   logic [EventWidth-1:0]  test, test_inc;
   logic                   wrapped;
   result_type             res;

   always_comb begin
      b_fire  = a_vld_ff && (ob_cnt_ff != 2'd2);
      a_ready = !a_vld_ff || b_fire;
      rec_pop = !rec_empty && a_ready;

      shamt      = rec.count - rec.taken;
      shifted    = {{CodeWidth{1'b0}}, rec.code} << shamt;
      a_short_in = rec.taken < rec.count;
      a_code_in  = a_short_in ? shifted[CodeWidth-1:0] : rec.code;
      a_vld_in   = rec_pop || (a_vld_ff && !b_fire);

      wrap_inc = wrap_ff + 1'b1;
      test     = {8'b0, wrap_ff, 16'b0} + EventWidth'(a_code_ff);
      test_inc = {8'b0, wrap_inc, 16'b0} + EventWidth'(a_code_ff);
      wrapped  = test < prev_ff;

      res.event_number = wrapped ? test_inc : test;
      res.wrap_count   = wrapped ? wrap_inc : wrap_ff;
      res.short_record = a_short_ff;

      wrap_in = b_fire ? res.wrap_count : wrap_ff;
      prev_in = b_fire ? res.event_number : prev_ff;

      ob_pop    = pop && (ob_cnt_ff != 2'd0);
      empty     = ob_cnt_ff == 2'd0;
      rsp       = ob_ff[ob_rd_ff];
      ob_wr_in  = b_fire ? !ob_wr_ff : ob_wr_ff;
      ob_rd_in  = ob_pop ? !ob_rd_ff : ob_rd_ff;
      ob_cnt_in = ob_cnt_ff + 2'(b_fire) - 2'(ob_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         wrap_ff   <= '0;
         prev_ff   <= '0;
         ob_wr_ff  <= 1'b0;
         ob_rd_ff  <= 1'b0;
         ob_cnt_ff <= '0;
      end else begin
         a_vld_ff  <= a_vld_in;
         wrap_ff   <= wrap_in;
         prev_ff   <= prev_in;
         ob_wr_ff  <= ob_wr_in;
         ob_rd_ff  <= ob_rd_in;
         ob_cnt_ff <= ob_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         a_code_ff  <= a_code_in;
         a_short_ff <= a_short_in;
      end
      if (b_fire) begin
         ob_ff[ob_wr_ff] <= res;
      end
   end

`ifndef SYNTHESIS
   a_wrap_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (wrap_ff == $past(wrap_ff) || wrap_ff == $past(wrap_ff) + 1'b1))
      else $error("back: wrap count moved by more than one");
   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      !b_fire |=> $stable(prev_ff))
      else $error("back: previous event changed without a result");
   a_ob_bound: assert property (@(posedge clock) disable iff (reset)
      ob_cnt_ff <= 2'd2)
      else $error("back: output buffer overflow");
`endif

endmodule

@@ sv/trigger_number_waveform_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger number waveform decoder
// The block takes one trigger-channel sample per clock while full is low and,
// at each record end, delivers one event number built from the sampled bit
// pattern and the running wrap count. A sample is taken in the cycle it is
// accepted; each finished record passes through the record queue, the padding
// stage and the output buffer, all registered; the front end adds no register.
// Samples and results flow at one per clock each while full is low and every
// result is popped; full rises only when the record queue holds four records
// the output side has not drained. Configuration writes are always ready and
// are meant to land while idle.
// ----------------------------------------------------------------------------
module trigger_number_waveform_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic signed [15:0]            req_sample_value,
   input  logic                          req_record_end,
   output logic                          empty,
   input  logic                          pop,
   output logic [tnwd_pkg::EventWidth-1:0] rsp_event_number,
   output logic [tnwd_pkg::WrapWidth-1:0]  rsp_wrap_count,
   output logic                          rsp_short_record,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_data
);
   import tnwd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic       rec_valid, rec_pop, rec_empty;
   record_type rec_wr, rec_rd;
   result_type rsp;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIRST_BIT: cfg_in.first_bit_index = csr_data;
            CSR_SPACING:   cfg_in.bit_spacing     = csr_data;
            CSR_COUNT:     cfg_in.bit_count       = csr_data[CntWidth-1:0];
            CSR_THRESHOLD: cfg_in.low_threshold   = csr_data;
            default:       cfg_in                 = cfg_ff;
         endcase
      end
      accept           = push && !full;
      rsp_event_number = rsp.event_number;
      rsp_wrap_count   = rsp.wrap_count;
      rsp_short_record = rsp.short_record;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_bit_index <= FirstBitReset;
         cfg_ff.bit_spacing     <= SpacingReset;
         cfg_ff.bit_count       <= CountReset;
         cfg_ff.low_threshold   <= ThresholdReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tnwd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .sample_valid (accept),
      .sample_value (req_sample_value),
      .record_end   (req_record_end),
      .rec_valid    (rec_valid),
      .rec          (rec_wr)
   );

   tnwd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rec_valid),
      .wr_data (rec_wr),
      .full    (full),
      .rd_en   (rec_pop),
      .rd_data (rec_rd),
      .empty   (rec_empty)
   );

   tnwd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_empty (rec_empty),
      .rec       (rec_rd),
      .rec_pop   (rec_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

endmodule

@@ tb/trigger_number_waveform_decoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger number decoder checker
// Watches the sample, result and register channels of the decoder. It keeps
// its own copy of the registers and of the record state, decodes every
// accepted sample and queues the event it expects at each record end. Each
// popped result is compared field by field with the oldest queued event.
// ----------------------------------------------------------------------------
module trigger_number_waveform_decoder_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            full,
   input  logic signed [15:0]              sample_value,
   input  logic                            record_end,
   input  logic                            empty,
   input  logic                            pop,
   input  logic [tnwd_pkg::EventWidth-1:0] event_number,
   input  logic [tnwd_pkg::WrapWidth-1:0]  wrap_count,
   input  logic                            short_record,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [15:0]                     csr_data,
   output int                              error_count,
   output int                              pending_results
);
   import tnwd_pkg::*;

   cfg_type                cfg;
   logic [16:0]            sample_idx;
   logic [16:0]            next_pos;
   logic [CodeWidth-1:0]   code_bits;
   logic [CntWidth-1:0]    bits_taken;
   logic [WrapWidth-1:0]   wraps;
   logic [EventWidth-1:0]  last_event;
   result_type             expected_events[$];

   task automatic restart_record();
      sample_idx = '0;
      next_pos   = {1'b0, cfg.first_bit_index};
      code_bits  = '0;
      bits_taken = '0;
   endtask

   task automatic decode_sample(input logic signed [15:0] value, input logic last);
      logic [CntWidth-1:0] n;
      logic [17:0]         sum;
      logic [63:0]         code;
      logic [63:0]         trial;
      logic                bit_val;
      result_type          res;
      n = (cfg.bit_count > MaxCodeBits) ? CntWidth'(MaxCodeBits) : cfg.bit_count;
      if (sample_idx == 0) begin
         next_pos = {1'b0, cfg.first_bit_index};
      end
      if (bits_taken < n && sample_idx < MaxRecordLen && sample_idx == next_pos) begin
         bit_val    = ($signed(value) < $signed(cfg.low_threshold));
         code_bits  = {code_bits[CodeWidth-2:0], bit_val};
         bits_taken = bits_taken + 1'b1;
         sum        = next_pos + cfg.bit_spacing;
         next_pos   = (sum > MaxRecordLen) ? 17'(MaxRecordLen) : sum[16:0];
      end
      if (!last) begin
         if (sample_idx < MaxRecordLen) begin
            sample_idx = sample_idx + 1'b1;
         end
      end else begin
         res.short_record = 1'b0;
         code = 64'(code_bits);
         if (bits_taken < n) begin
            res.short_record = 1'b1;
            code = (code << (n - bits_taken)) & 64'hFFFF_FFFF;
         end
         trial = code + (64'(wraps) << 16);
         if (trial < 64'(last_event)) begin
            wraps = wraps + 1'b1;
         end
         res.event_number = EventWidth'(code + (64'(wraps) << 16));
         res.wrap_count   = wraps;
         last_event       = res.event_number;
         expected_events.insert(expected_events.size(), res);
         restart_record();
      end
   endtask

   task automatic check_event();
      result_type exp_res;
      if (expected_events.size() == 0) begin
         $display("%0t: unexpected result, got event_number %0h wrap_count %0h short_record %0b",
                  $time, event_number, wrap_count, short_record);
         error_count++;
      end else begin
         exp_res = expected_events.pop_front();
         if (event_number !== exp_res.event_number) begin
            $display("%0t: event_number expected %0h, got %0h",
                     $time, exp_res.event_number, event_number);
            error_count++;
         end
         if (wrap_count !== exp_res.wrap_count) begin
            $display("%0t: wrap_count expected %0h, got %0h",
                     $time, exp_res.wrap_count, wrap_count);
            error_count++;
         end
         if (short_record !== exp_res.short_record) begin
            $display("%0t: short_record expected %0b, got %0b",
                     $time, exp_res.short_record, short_record);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.first_bit_index = FirstBitReset;
         cfg.bit_spacing     = SpacingReset;
         cfg.bit_count       = CountReset;
         cfg.low_threshold   = ThresholdReset;
         wraps               = '0;
         last_event          = '0;
         restart_record();
         expected_events.delete();
      end else begin
         if (pop && !empty) begin
            check_event();
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_BIT: cfg.first_bit_index = csr_data;
               CSR_SPACING:   cfg.bit_spacing     = csr_data;
               CSR_COUNT:     cfg.bit_count       = csr_data[CntWidth-1:0];
               CSR_THRESHOLD: cfg.low_threshold   = csr_data;
               default: ;
            endcase
         end
         if (push && !full) begin
            decode_sample(sample_value, record_end);
         end
      end
      pending_results = expected_events.size();
   end

endmodule

@@ tb/trigger_number_waveform_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trigger number decoder testbench
// Drives sample records and register settings into the decoder and pops its
// results, with random gaps on both sides and a long output hold-off. A
// checker beside the decoder predicts and compares every result; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module trigger_number_waveform_decoder_tb;
   import tnwd_pkg::*;

   typedef enum logic [1:0] {
      FILL_MIXED,
      FILL_LOW,
      FILL_HIGH
   } fill_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  push             = 1'b0;
   logic                  full;
   logic signed [15:0]    req_sample_value = '0;
   logic                  req_record_end   = 1'b0;
   logic                  empty;
   logic                  pop              = 1'b0;
   logic [EventWidth-1:0] rsp_event_number;
   logic [WrapWidth-1:0]  rsp_wrap_count;
   logic                  rsp_short_record;
   logic                  csr_valid        = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index        = '0;
   logic [15:0]           csr_data         = '0;

   int                    error_count;
   int                    pending_results;
   int                    send_idle_pct    = 0;
   int                    recv_idle_pct    = 0;
   logic                  hold_req         = 1'b0;
   int                    samples_sent     = 0;
   int                    records_sent     = 0;
   logic signed [15:0]    cur_threshold    = ThresholdReset;
   int                    cur_first        = FirstBitReset;
   int                    cur_spacing      = SpacingReset;
   int                    cur_count        = CountReset;

   trigger_number_waveform_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_sample_value (req_sample_value),
      .req_record_end   (req_record_end),
      .empty            (empty),
      .pop              (pop),
      .rsp_event_number (rsp_event_number),
      .rsp_wrap_count   (rsp_wrap_count),
      .rsp_short_record (rsp_short_record),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   trigger_number_waveform_decoder_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .sample_value    (req_sample_value),
      .record_end      (req_record_end),
      .empty           (empty),
      .pop             (pop),
      .event_number    (rsp_event_number),
      .wrap_count      (rsp_wrap_count),
      .short_record    (rsp_short_record),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(5))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return cur_threshold - 16'sd1;
         3:       return cur_threshold;
         4:       return cur_threshold + 16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [15:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push             <= 1'b1;
      req_sample_value <= value;
      req_record_end   <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      samples_sent++;
      if (last) begin
         records_sent++;
      end
   endtask

   task automatic send_record(input int len, input fill_type fill, input logic ends);
      logic signed [15:0] value;
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_LOW:  value = 16'sh8000;
            FILL_HIGH: value = 16'sh7FFF;
            default:   value = pick_sample();
         endcase
         send_sample(value, ends && (i == len - 1));
      end
   endtask

   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      wait (pending_results == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] first, input logic [15:0] spacing,
                             input logic [5:0] count, input logic signed [15:0] thr);
      settle();
      write_reg(CSR_FIRST_BIT, first);
      write_reg(CSR_SPACING, spacing);
      write_reg(CSR_COUNT, {10'd0, count});
      write_reg(CSR_THRESHOLD, thr);
      cur_first     = first;
      cur_spacing   = spacing;
      cur_count     = count;
      cur_threshold = thr;
   endtask

   task automatic run_random(input int min_samples, input int min_records);
      int                 start_samples;
      int                 start_records;
      int                 n;
      int                 span;
      int                 len;
      logic [15:0]        first;
      logic [15:0]        spacing;
      logic [5:0]         count;
      logic signed [15:0] thr;
      start_samples = samples_sent;
      start_records = records_sent;
      while (samples_sent - start_samples < min_samples ||
             records_sent - start_records < min_records) begin
         first   = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
         spacing = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
         count   = ($urandom_range(5) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, 10));
         thr     = ($urandom_range(1) == 0) ? 16'($urandom)
                                            : 16'($urandom_range(0, 1000)) - 16'sd500;
         set_config(first, spacing, count, thr);
         repeat ($urandom_range(3, 6)) begin
            n    = (cur_count > 32) ? 32 : cur_count;
            span = cur_first + cur_spacing * ((n > 0) ? n - 1 : 0) + 1;
            if (span > 48) begin
               len = $urandom_range(1, 48);
            end else if ($urandom_range(99) < 80) begin
               len = span + $urandom_range(0, 3);
            end else begin
               len = $urandom_range(1, span);
            end
            send_record(len, FILL_MIXED, 1'b1);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 36;
      recv_idle_pct <= 51;
      @(posedge clock);

      // Reset settings: a record that ends before the first bit position.
      send_record(24, FILL_MIXED, 1'b1);

      set_config(16'd2, 16'd3, 6'd4, -16'sd400);
      send_record(12, FILL_LOW, 1'b1);
      send_record(12, FILL_HIGH, 1'b1);
      send_record(12, FILL_MIXED, 1'b1);
      send_record(7, FILL_MIXED, 1'b1);
      send_record(1, FILL_MIXED, 1'b1);

      set_config(16'd0, 16'd1, 6'd32, 16'sd0);
      send_record(32, FILL_MIXED, 1'b1);
      send_record(32, FILL_LOW, 1'b1);
      send_record(32, FILL_HIGH, 1'b1);

      set_config(16'd0, 16'd1, 6'd0, 16'sd100);
      send_record(3, FILL_LOW, 1'b1);
      settle();
      write_reg(CSR_COUNT, 16'd63);
      cur_count = 63;
      send_record(40, FILL_MIXED, 1'b1);
      send_record(10, FILL_LOW, 1'b1);

      set_config(16'd1, 16'd0, 6'd5, -16'sd400);
      send_record(6, FILL_LOW, 1'b1);

      set_config(16'd0, 16'd1, 6'd4, 16'sh8000);
      send_record(4, FILL_LOW, 1'b1);
      set_config(16'd0, 16'd1, 6'd4, 16'sh7FFF);
      send_record(4, FILL_HIGH, 1'b1);
      send_record(4, FILL_MIXED, 1'b1);

      set_config(16'hFFFF, 16'hFFFF, 6'd3, -16'sd400);
      send_record(4, FILL_LOW, 1'b1);
      set_config(16'd0, 16'hFFFF, 6'd3, -16'sd400);
      send_record(4, FILL_LOW, 1'b1);

      // Bit count lowered in the middle of a record.
      set_config(16'd0, 16'd1, 6'd8, -16'sd400);
      send_record(6, FILL_MIXED, 1'b0);
      settle();
      write_reg(CSR_COUNT, 16'd3);
      cur_count = 3;
      send_sample(pick_sample(), 1'b1);

      // The first bit position only takes effect on the next record.
      set_config(16'd0, 16'd2, 6'd3, -16'sd400);
      send_record(3, FILL_LOW, 1'b0);
      settle();
      write_reg(CSR_FIRST_BIT, 16'd4);
      cur_first = 4;
      send_record(3, FILL_LOW, 1'b1);
      send_record(9, FILL_MIXED, 1'b1);

      run_random(50, 3);

      settle();
      send_idle_pct <= 51;
      recv_idle_pct <= 36;
      run_random(50, 3);

      settle();
      send_idle_pct <= 0;
      recv_idle_pct <= 0;

      // Hold the output side off while one-sample records keep arriving.
      set_config(16'd0, 16'd1, 6'd1, -16'sd400);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      send_record(1, FILL_LOW, 1'b1);
      repeat (23) send_record(1, FILL_MIXED, 1'b1);

      run_random(50, 3);

      settle();
      if (error_count == 0 && pending_results == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/tnwd_pkg.sv
sv/tnwd_front.sv
sv/tnwd_queue.sv
sv/tnwd_back.sv
sv/trigger_number_waveform_decoder.sv
tb/trigger_number_waveform_decoder_checker.sv
tb/trigger_number_waveform_decoder_tb.sv
